>>> rtl/icmpv6_header_parser_top_defines.svh
// Assertion macros for the ICMPv6 header parser
`ifndef ICMPV6_HEADER_PARSER_TOP_DEFINES_SVH
`define ICMPV6_HEADER_PARSER_TOP_DEFINES_SVH
// Implication checked on every rising clock edge out of reset
`define ICP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define ICP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> rtl/icp_pkg.sv
// ----------------------------------------------------------------------------
// icp_pkg
// Types and constants shared by the ICMPv6 header parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package icp_pkg;
  localparam logic [5:0] POS_SAT = 6'd40;
  localparam logic [7:0] RA_RES_MASK = 8'h3F;
  localparam logic [31:0] NA_RES_MASK = 32'h1FFFFFFF;
  localparam int NA_R_BIT = 31;
  localparam int NA_S_BIT = 30;
  localparam int NA_O_BIT = 29;
  localparam int RA_M_BIT = 7;
  localparam int RA_O_BIT = 6;

  typedef enum logic [3:0] {
    TAG_NONE = 4'd0, TAG_TYPE = 4'd1, TAG_CODE = 4'd2, TAG_CSUM = 4'd3,
    TAG_TWORD = 4'd4, TAG_ECHO_ID = 4'd5, TAG_ECHO_SEQ = 4'd6, TAG_HOP = 4'd7,
    TAG_RA_FLAGS = 4'd8, TAG_LIFE = 4'd9, TAG_REACH = 4'd10, TAG_RETRANS = 4'd11,
    TAG_NA_FLAGS = 4'd12, TAG_TARGET = 4'd13, TAG_DEST = 4'd14, TAG_BODY = 4'd15
  } tag_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_MISSING = 2'd1, ST_NOT_IMPL = 2'd2
  } status_t;

  // Classified byte passed from the front to the back
  typedef struct packed {
    logic [7:0]  byte_req;
    logic        last;
    logic [5:0]  pos;
    logic [7:0]  mtype;
    logic [5:0]  flen;
    logic [31:0] word;
  } cls_t;

  typedef struct packed {
    logic [3:0]  tag;
    logic [31:0] value;
    logic [1:0]  word_index;
    logic        flag_a;
    logic        flag_b;
    logic        flag_c;
    logic        end_of_message;
    logic [1:0]  status;
  } res_t;

  function automatic logic [5:0] fixed_len(input logic [7:0] t);
    case (t)
      8'd1, 8'd2, 8'd3, 8'd4, 8'd128, 8'd129, 8'd133: fixed_len = 6'd8;
      8'd134: fixed_len = 6'd16;
      8'd135, 8'd136: fixed_len = 6'd24;
      8'd137: fixed_len = 6'd40;
      default: fixed_len = 6'd0;
    endcase
  endfunction
endpackage
`default_nettype wire

>>> rtl/icp_if.sv
// ----------------------------------------------------------------------------
// icp_in_if / icp_out_if
// Valid/ready channels for message bytes and parse results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface icp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_req;
  logic       last;
  modport source (output valid, output byte_req, output last, input ready);
  modport sink (input valid, input byte_req, input last, output ready);
endinterface

interface icp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  tag;
  logic [31:0] value;
  logic [1:0]  word_index;
  logic        flag_a;
  logic        flag_b;
  logic        flag_c;
  logic        end_of_message;
  logic [1:0]  status;
  modport source (output valid, output tag, output value, output word_index,
                  output flag_a, output flag_b, output flag_c,
                  output end_of_message, output status, input ready);
  modport sink (input valid, input tag, input value, input word_index,
                input flag_a, input flag_b, input flag_c,
                input end_of_message, input status, output ready);
endinterface
`default_nettype wire

>>> rtl/icp_front.sv
// ----------------------------------------------------------------------------
// icp_front
// Tracks byte position, type and the gathered bytes; classifies each byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module icp_front (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire [7:0]        in_byte_req,
  input  wire              in_last,
  output logic             cls_valid,
  input  wire              cls_ready,
  output icp_pkg::cls_t    cls_data
);
  import icp_pkg::*;

  logic [5:0]  pos_r, pos_nxt;
  logic [7:0]  mtype_r, mtype_nxt;
  logic [23:0] gather_r, gather_nxt;
  logic [7:0]  t;
  logic        acc;

  assign in_ready  = cls_ready;
  assign cls_valid = in_valid;
  assign acc       = in_valid && cls_ready;
  assign t         = (pos_r == 6'd0) ? in_byte_req : mtype_r;

  always_comb begin
    cls_data.byte_req = in_byte_req;
    cls_data.last     = in_last;
    cls_data.pos      = pos_r;
    cls_data.mtype    = t;
    cls_data.flen     = fixed_len(t);
    cls_data.word     = {gather_r, in_byte_req};
  end

  always_comb begin
    pos_nxt    = pos_r;
    mtype_nxt  = mtype_r;
    gather_nxt = gather_r;
    if (acc) begin
      if (in_last) begin
        pos_nxt    = 6'd0;
        mtype_nxt  = 8'd0;
        gather_nxt = 24'd0;
      end else begin
        pos_nxt    = (pos_r < POS_SAT) ? pos_r + 6'd1 : POS_SAT;
        mtype_nxt  = t;
        gather_nxt = {gather_r[15:0], in_byte_req};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= 6'd0;
      mtype_r  <= 8'd0;
      gather_r <= 24'd0;
    end else begin
      pos_r    <= pos_nxt;
      mtype_r  <= mtype_nxt;
      gather_r <= gather_nxt;
    end
  end
endmodule
`default_nettype wire

>>> rtl/icp_queue.sv
// ----------------------------------------------------------------------------
// icp_queue
// Two-entry queue between the classifier and the field decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module icp_queue (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              wr_valid,
  output logic             wr_ready,
  input  icp_pkg::cls_t    wr_data,
  output logic             rd_valid,
  input  wire              rd_ready,
  output icp_pkg::cls_t    rd_data
);
  import icp_pkg::*;

  cls_t        mem_r [2];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        wr, rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;
  assign rd_data  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wr ? ~wp_r : wp_r;
    rp_nxt  = rd ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, wr} - {1'b0, rd};
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

>>> rtl/icp_back.sv
// ----------------------------------------------------------------------------
// icp_back
// Decodes the field each classified byte completes into a result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module icp_back (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              cls_valid,
  output logic             cls_ready,
  input  icp_pkg::cls_t    cls_data,
  output logic             res_valid,
  input  wire              res_ready,
  output icp_pkg::res_t    res_data
);
  import icp_pkg::*;

  res_t       r;
  res_t       res_r;
  logic       valid_r;
  logic [5:0] p, len, off;
  logic [7:0] b;
  logic [31:0] w;

  assign cls_ready = !valid_r || res_ready;
  assign res_valid = valid_r;
  assign res_data  = res_r;
  assign p   = cls_data.pos;
  assign b   = cls_data.byte_req;
  assign w   = cls_data.word;
  assign len = p + 6'd1;
  assign off = (p < 6'd24) ? p - 6'd8 : p - 6'd24;

  always_comb begin
    r = '0;
    if (p == 6'd0) begin
      r.tag = TAG_TYPE; r.value = {24'd0, b};
    end else if (p == 6'd1) begin
      r.tag = TAG_CODE; r.value = {24'd0, b};
    end else if (p == 6'd3) begin
      r.tag = TAG_CSUM; r.value = {16'd0, w[15:0]};
    end else if (p >= 6'd4 && cls_data.flen != 6'd0) begin
      if (p >= cls_data.flen) begin
        r.tag = TAG_BODY; r.value = {24'd0, b};
      end else if (cls_data.mtype == 8'd128 || cls_data.mtype == 8'd129) begin
        if (p == 6'd5) begin
          r.tag = TAG_ECHO_ID; r.value = {16'd0, w[15:0]};
        end else if (p == 6'd7) begin
          r.tag = TAG_ECHO_SEQ; r.value = {16'd0, w[15:0]};
        end
      end else if (cls_data.mtype == 8'd134) begin
        if (p == 6'd4) begin
          r.tag = TAG_HOP; r.value = {24'd0, b};
        end else if (p == 6'd5) begin
          r.tag = TAG_RA_FLAGS; r.value = {24'd0, b & RA_RES_MASK};
          r.flag_a = b[RA_M_BIT]; r.flag_b = b[RA_O_BIT];
        end else if (p == 6'd7) begin
          r.tag = TAG_LIFE; r.value = {16'd0, w[15:0]};
        end else if (p == 6'd11) begin
          r.tag = TAG_REACH; r.value = w;
        end else if (p == 6'd15) begin
          r.tag = TAG_RETRANS; r.value = w;
        end
      end else if (p == 6'd7) begin
        if (cls_data.mtype == 8'd136) begin
          r.tag = TAG_NA_FLAGS; r.value = w & NA_RES_MASK;
          r.flag_a = w[NA_R_BIT]; r.flag_b = w[NA_S_BIT]; r.flag_c = w[NA_O_BIT];
        end else begin
          r.tag = TAG_TWORD; r.value = w;
        end
      end else if (p[1:0] == 2'd3 && p >= 6'd8) begin
        r.tag = (p < 6'd24) ? TAG_TARGET : TAG_DEST;
        r.value = w;
        r.word_index = off[3:2];
      end
    end
    if (cls_data.last) begin
      r.end_of_message = 1'b1;
      if (len < 6'd4) r.status = ST_MISSING;
      else if (cls_data.flen == 6'd0) r.status = ST_NOT_IMPL;
      else if (len < cls_data.flen) r.status = ST_MISSING;
      else r.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cls_valid && cls_ready) res_r <= r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cls_ready) begin
      valid_r <= cls_valid;
    end
  end
endmodule
`default_nettype wire

>>> rtl/icmpv6_header_parser_top.sv
// ----------------------------------------------------------------------------
// icmpv6_header_parser_top
// Byte-wise ICMPv6 header field parser.
// ----------------------------------------------------------------------------
// channel  dir  contents
// in_      in   byte_req, last
// out_     out  tag, value, word_index, flag_a/b/c, end_of_message, status
//
// One byte per cycle sustained while the output accepts results. A result is
// registered after its byte's transfer, first in the two-entry queue, then in
// the decoder's output register.
// The delay is set by the queue and result register; the position counter
// updates only when a byte is accepted.
// Reset (rst_n low, synchronous) clears position, type, queue and result valid.
// Either side may stall; the queue absorbs up to two bytes.
`timescale 1ns / 1ps
`default_nettype none
module icmpv6_header_parser_top (
  input wire        clk,
  input wire        rst_n,
  icp_in_if.sink    in_ch,
  icp_out_if.source out_ch
);
  import icp_pkg::*;

  cls_t f_data, q_data;
  res_t res;
  logic f_valid, f_ready, q_valid, q_ready;

  icp_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_byte_req(in_ch.byte_req), .in_last(in_ch.last),
    .cls_valid(f_valid), .cls_ready(f_ready), .cls_data(f_data)
  );

  icp_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  icp_back u_back (
    .clk(clk), .rst_n(rst_n),
    .cls_valid(q_valid), .cls_ready(q_ready), .cls_data(q_data),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res_data(res)
  );

  assign out_ch.tag            = res.tag;
  assign out_ch.value          = res.value;
  assign out_ch.word_index     = res.word_index;
  assign out_ch.flag_a         = res.flag_a;
  assign out_ch.flag_b         = res.flag_b;
  assign out_ch.flag_c         = res.flag_c;
  assign out_ch.end_of_message = res.end_of_message;
  assign out_ch.status         = res.status;
endmodule
`default_nettype wire

>>> rtl/icp_checker.sv
// ----------------------------------------------------------------------------
// icp_port_checker
// Port-level checks on the parser's result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "icmpv6_header_parser_top_defines.svh"
module icp_port_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_ready,
  input wire [3:0]  out_tag,
  input wire [31:0] out_value,
  input wire [1:0]  out_status,
  input wire        out_end_of_message
);
  import icp_pkg::*;

  `ICP_ASSERT_IMP(a_status_only_at_end, clk, rst_n,
                  out_valid && !out_end_of_message, out_status == ST_OK, "status off end")
  `ICP_ASSERT_IMP(a_none_zero, clk, rst_n,
                  out_valid && out_tag == TAG_NONE, out_value == 32'd0, "tag none with value")
  `ICP_ASSERT_IMP(a_status_range, clk, rst_n, out_valid, out_status != 2'd3, "bad status")
  `ICP_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready,
                  out_valid && $stable(out_value), "stalled result changed")
endmodule

bind icmpv6_header_parser_top icp_port_checker u_icp_checker (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_tag(out_ch.tag), .out_value(out_ch.value),
  .out_status(out_ch.status), .out_end_of_message(out_ch.end_of_message)
);
`default_nettype wire
